// ===== src/bchc_pkg.sv =====
// Shared types and constants for the button click / hold classifier.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bchc_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_DEBOUNCE     = 2'd0,
        CFG_HOLD         = 2'd1,
        CFG_SVC_TIMEOUT  = 2'd2,
        CFG_REL_DEBOUNCE = 2'd3
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int TIMEOUT_W  = 24;
    localparam int TICKS_W    = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    localparam logic [TICKS_W-1:0]   DEBOUNCE_RST     = 16'd50;
    localparam logic [TICKS_W-1:0]   HOLD_RST         = 16'd5000;
    localparam logic [TIMEOUT_W-1:0] SVC_TIMEOUT_RST  = 24'd300000;
    localparam logic [TICKS_W-1:0]   REL_DEBOUNCE_RST = 16'd200;

    typedef struct packed {
        logic [TICKS_W-1:0]   debounce_ticks;
        logic [TICKS_W-1:0]   hold_ticks;
        logic [TIMEOUT_W-1:0] service_timeout_ticks;
        logic [TICKS_W-1:0]   release_debounce_ticks;
    } t_cfg;

    // Single-bit state flags of the classifier.
    typedef struct packed {
        logic in_service;
        logic lockout_active;
        logic held;
        logic release_seen;
        logic previous_level;
    } t_flags;

    // One result item; packed MSB first so bit 0 is toggle_pulse.
    typedef struct packed {
        logic lockout;
        logic service_mode;
        logic restart_pulse;
        logic enter_service_pulse;
        logic toggle_pulse;
    } t_result;

    localparam int RESULT_W = 5;

endpackage

`default_nettype wire

// ===== src/bchc_step.sv =====
// Next-state and result logic for one tick of the classifier.
// Purely combinational; depends on bchc_pkg.
`default_nettype none

module bchc_step #(
    parameter int COUNT_BITS = 24
) (
    input  wire bchc_pkg::t_cfg      i_cfg,
    input  wire                      i_level,
    input  wire bchc_pkg::t_flags    i_flags,
    input  wire [COUNT_BITS-1:0]     i_phase_count,
    input  wire [COUNT_BITS-1:0]     i_service_count,
    input  wire [COUNT_BITS-1:0]     i_release_count,
    output bchc_pkg::t_flags         o_flags,
    output logic [COUNT_BITS-1:0]    o_phase_count,
    output logic [COUNT_BITS-1:0]    o_service_count,
    output logic [COUNT_BITS-1:0]    o_release_count,
    output bchc_pkg::t_result        o_result
);
    import bchc_pkg::*;

    localparam int CMP_W = (COUNT_BITS > TIMEOUT_W) ? COUNT_BITS : TIMEOUT_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    always_comb begin
        t_flags                f;
        logic [COUNT_BITS-1:0] ph;
        logic [COUNT_BITS-1:0] sv;
        logic [COUNT_BITS-1:0] rl;
        logic                  toggle;
        logic                  enter;
        logic                  restart;

        f       = i_flags;
        ph      = i_phase_count;
        sv      = i_service_count;
        rl      = i_release_count;
        toggle  = 1'b0;
        enter   = 1'b0;
        restart = 1'b0;

        if (f.in_service) begin
            sv = sat_inc(sv);
            if (f.release_seen) begin
                rl = sat_inc(rl);
            end
            if (CMP_W'(sv) > CMP_W'(i_cfg.service_timeout_ticks)) begin
                restart = 1'b1;
            end
            // first release after entry arms the re-press check
            if (!i_level && f.previous_level && !f.release_seen) begin
                f.release_seen = 1'b1;
                rl = '0;
            end
            if (i_level && !f.previous_level && f.release_seen &&
                rl >= COUNT_BITS'(i_cfg.release_debounce_ticks)) begin
                restart = 1'b1;
            end
            f.previous_level = i_level;
            if (restart) begin
                f  = '0;
                ph = '0;
                sv = '0;
                rl = '0;
            end
        end else if (f.lockout_active) begin
            // button ignored, including on the tick the lockout ends
            ph = sat_inc(ph);
            if (ph >= COUNT_BITS'(i_cfg.debounce_ticks)) begin
                f.lockout_active = 1'b0;
            end
        end else begin
            if (f.held) begin
                ph = sat_inc(ph);
            end
            if (i_level && !f.held) begin
                f.held = 1'b1;
                ph = '0;
            end
            if (i_level && f.held && ph >= COUNT_BITS'(i_cfg.hold_ticks)) begin
                f.in_service     = 1'b1;
                f.release_seen   = 1'b0;
                f.previous_level = 1'b1;
                f.held           = 1'b0;
                sv    = '0;
                rl    = '0;
                enter = 1'b1;
            end else if (!i_level && f.held) begin
                toggle = (ph < COUNT_BITS'(i_cfg.hold_ticks));
                f.held           = 1'b0;
                f.lockout_active = 1'b1;
                ph = '0;
            end
        end

        o_flags         = f;
        o_phase_count   = ph;
        o_service_count = sv;
        o_release_count = rl;
        o_result.toggle_pulse        = toggle;
        o_result.enter_service_pulse = enter;
        o_result.restart_pulse       = restart;
        o_result.service_mode        = f.in_service;
        o_result.lockout             = f.lockout_active;
    end

endmodule

`default_nettype wire

// ===== src/bchc_obuf.sv =====
// Output holding register for result transfers.
// Depends on bchc_pkg; drives the master-side stream handshake.
`default_nettype none

module bchc_obuf (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  wire bchc_pkg::t_result i_result,
    output logic                o_room,
    output logic                o_tvalid,
    input  wire                 i_tready,
    output bchc_pkg::t_result   o_result
);
    import bchc_pkg::*;

    logic    r_valid;
    t_result r_result;

    // take a new result whenever the held one is gone or leaves this cycle
    assign o_room   = !r_valid || i_tready;
    assign o_tvalid = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ===== src/button_click_hold_classifier.sv =====
// Top level of the button click / hold classifier: configuration registers,
// tick state registers, and the step and output stages. Depends on bchc_pkg.
// ---------------------------------------------------------------------------
// Usage
//   Input stream (s_axis): one transfer per time tick; tdata bit 0 is the
//   sampled button level (1 = pressed). Output stream (m_axis): one result
//   transfer per input tick carrying toggle, enter-service and restart
//   pulses plus the service-mode and lockout levels after that tick.
//   Configuration: write i_cfg_wdata to register i_cfg_index when i_cfg_we
//   is high; only write while no tick is in flight.
// Timing and throughput
//   A result appears on m_axis in the cycle after its tick transfers in. One
//   tick is accepted every cycle while m_axis does not stall; the state
//   update is a single pass of counter increments and compares between
//   the state registers and the output register.
// Reset
//   i_rst_n (synchronous, active low) clears all tick state, empties the
//   output register and loads the register defaults (50, 5000, 300000, 200).
//   A restart request returns the tick state to reset but keeps the
//   configuration registers.
// Stall
//   While a result waits on m_axis and i_m_axis_tready is low, s_axis is
//   held off; no tick is dropped. A result leaving frees room for the next
//   tick in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module button_click_hold_classifier #(
    parameter int COUNT_BITS = 24
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // configuration write port
    input  wire                             i_cfg_we,
    input  wire [bchc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [bchc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // tick input stream
    input  wire                             i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire [bchc_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // [0] button_level
    // result output stream
    output logic                            o_m_axis_tvalid,
    input  wire                             i_m_axis_tready,
    // [0] toggle_pulse, [1] enter_service_pulse, [2] restart_pulse,
    // [3] service_mode, [4] lockout, [7:5] zero
    output logic [bchc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import bchc_pkg::*;

    t_cfg                  r_cfg;
    t_flags                r_flags;
    logic [COUNT_BITS-1:0] r_phase_count;
    logic [COUNT_BITS-1:0] r_service_count;
    logic [COUNT_BITS-1:0] r_release_count;

    t_flags                n_flags;
    logic [COUNT_BITS-1:0] n_phase_count;
    logic [COUNT_BITS-1:0] n_service_count;
    logic [COUNT_BITS-1:0] n_release_count;
    t_result               n_result;
    t_result               w_out_result;
    logic                  w_room;
    logic                  w_accept;

    assign o_s_axis_tready = w_room;
    assign w_accept        = i_s_axis_tvalid && w_room;

    // configuration registers; unused high data bits are dropped per register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks         <= DEBOUNCE_RST;
            r_cfg.hold_ticks             <= HOLD_RST;
            r_cfg.service_timeout_ticks  <= SVC_TIMEOUT_RST;
            r_cfg.release_debounce_ticks <= REL_DEBOUNCE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE:     r_cfg.debounce_ticks         <= i_cfg_wdata[TICKS_W-1:0];
                CFG_HOLD:         r_cfg.hold_ticks             <= i_cfg_wdata[TICKS_W-1:0];
                CFG_SVC_TIMEOUT:  r_cfg.service_timeout_ticks  <= i_cfg_wdata[TIMEOUT_W-1:0];
                CFG_REL_DEBOUNCE: r_cfg.release_debounce_ticks <= i_cfg_wdata[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    bchc_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_cfg           (r_cfg),
        .i_level         (i_s_axis_tdata[0]),
        .i_flags         (r_flags),
        .i_phase_count   (r_phase_count),
        .i_service_count (r_service_count),
        .i_release_count (r_release_count),
        .o_flags         (n_flags),
        .o_phase_count   (n_phase_count),
        .o_service_count (n_service_count),
        .o_release_count (n_release_count),
        .o_result        (n_result)
    );

    // advance tick state on every accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags         <= '0;
            r_phase_count   <= '0;
            r_service_count <= '0;
            r_release_count <= '0;
        end else if (w_accept) begin
            r_flags         <= n_flags;
            r_phase_count   <= n_phase_count;
            r_service_count <= n_service_count;
            r_release_count <= n_release_count;
        end
    end

    bchc_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_result (n_result),
        .o_room   (w_room),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_result (w_out_result)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-RESULT_W){1'b0}}, w_out_result};

`ifndef SYNTH
    // service mode and click lockout are mutually exclusive
    a_mode_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_flags.in_service && r_flags.lockout_active))
        else $error("service mode and lockout active together");

    // a restart result always reports the cleared state
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_out_result.restart_pulse) |->
            (!w_out_result.service_mode && !w_out_result.lockout))
        else $error("restart result with service mode or lockout set");

    // entering service reports service mode and never a toggle
    a_enter_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_out_result.enter_service_pulse) |->
            (w_out_result.service_mode && !w_out_result.toggle_pulse))
        else $error("enter pulse without service mode");

    // an accepted tick always leaves a result waiting on the next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_m_axis_tvalid)
        else $error("accepted tick produced no result");
`endif

endmodule

`default_nettype wire

// ===== test/tb_button_click_hold_classifier.sv =====
// Self-checking testbench for button_click_hold_classifier: a tick stream of
// button levels with random gaps and result stalls, checked against an inline
// predictor of the classifier. Depends on bchc_pkg and the block's top level.
`timescale 1ns / 100ps

module tb_button_click_hold_classifier;
    import bchc_pkg::*;

    localparam int          CNT_W       = 24;   // counter width given to the block
    localparam int unsigned STALL_LIMIT = 500;  // cycles without any transfer
    localparam int unsigned PHASE_TICKS = 135;  // random ticks per settings phase
    localparam int unsigned PHASES      = 12;

    // How often a side idles: never, now and then, or for a random gap at every transfer.
    typedef enum int {PACE_NONE, PACE_SPARSE, PACE_FULL} t_pace;

    // One pending tick: the level to send and the idle cycles ahead of it.
    typedef struct {
        logic        level;
        int unsigned gap;
    } t_tick_item;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata     = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;  // [0] button_level, rest zero
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [0] toggle_pulse, [1] enter_service_pulse, [2] restart_pulse,
    // [3] service_mode, [4] lockout
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    button_click_hold_classifier #(
        .COUNT_BITS(CNT_W)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Classifier predictor: shadow registers and tick state
    // -----------------------------------------------------------------------
    t_cfg             cfg_shadow;
    logic             in_svc, lock_on, press_held, rel_seen, last_level;
    logic [CNT_W-1:0] press_cnt, svc_cnt, rel_cnt;

    t_tick_item  tick_q[$];     // ticks waiting for the driver
    t_result     verdict_q[$];  // predicted results, oldest first
    t_pace       pace = PACE_FULL;
    int unsigned errors = 0;
    int unsigned n_ticks = 0, n_clicks = 0, n_entries = 0, n_restarts = 0;
    int unsigned tx_wait = 0, rx_wait = 0, stall_cycles = 0;

    function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Drop all tick state back to its reset value; registers are kept.
    task automatic clear_tracker();
        in_svc     = 1'b0;
        lock_on    = 1'b0;
        press_held = 1'b0;
        rel_seen   = 1'b0;
        last_level = 1'b0;
        press_cnt  = '0;
        svc_cnt    = '0;
        rel_cnt    = '0;
    endtask

    // Advance the predictor by one tick and return the result it must produce.
    task automatic classify_tick(input logic pressed, output t_result res);
        res = '0;
        if (in_svc) begin
            svc_cnt = sat_bump(svc_cnt);
            if (rel_seen)
                rel_cnt = sat_bump(rel_cnt);
            // timeout fires only once the service time is strictly past the limit
            if (svc_cnt > cfg_shadow.service_timeout_ticks)
                res.restart_pulse = 1'b1;
            // first release in service mode starts the re-press timer
            if (!pressed && last_level && !rel_seen) begin
                rel_seen = 1'b1;
                rel_cnt  = '0;
            end
            // a re-press far enough from the release asks for a restart too;
            // on the same tick as the timeout it is still one pulse
            if (pressed && !last_level && rel_seen &&
                rel_cnt >= cfg_shadow.release_debounce_ticks)
                res.restart_pulse = 1'b1;
            last_level = pressed;
            if (res.restart_pulse)
                clear_tracker();
        end else if (lock_on) begin
            // the button is ignored for the whole lockout, its last tick too
            press_cnt = sat_bump(press_cnt);
            if (press_cnt >= cfg_shadow.debounce_ticks)
                lock_on = 1'b0;
        end else begin
            if (press_held)
                press_cnt = sat_bump(press_cnt);
            if (pressed && !press_held) begin
                press_held = 1'b1;
                press_cnt  = '0;
            end
            // with a zero hold time the press enters service on its first tick
            if (pressed && press_held && press_cnt >= cfg_shadow.hold_ticks) begin
                in_svc     = 1'b1;
                svc_cnt    = '0;
                rel_seen   = 1'b0;
                rel_cnt    = '0;
                last_level = 1'b1;
                press_held = 1'b0;
                res.enter_service_pulse = 1'b1;
            end else if (!pressed && press_held) begin
                if (press_cnt < cfg_shadow.hold_ticks)
                    res.toggle_pulse = 1'b1;
                press_held = 1'b0;
                lock_on    = 1'b1;
                press_cnt  = '0;
            end
        end
        res.service_mode = in_svc;
        res.lockout      = lock_on;
    endtask

    function automatic int unsigned draw_gap();
        case (pace)
            PACE_NONE:   return 0;
            PACE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
            default:     return $urandom_range(0, 16);
        endcase
    endfunction

    function automatic void check_field(input string name, input logic want,
                                        input logic got);
        if (want !== got) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            errors++;
        end
    endfunction

    // -----------------------------------------------------------------------
    // Driver: present queued ticks, predict each one as it transfers
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_ticks
        t_tick_item nxt;
        t_result    want;
        logic       presenting;
        presenting = i_s_axis_tvalid;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                classify_tick(i_s_axis_tdata[0], want);
                verdict_q.push_back(want);
                n_ticks++;
                n_clicks   += int'(want.toggle_pulse);
                n_entries  += int'(want.enter_service_pulse);
                n_restarts += int'(want.restart_pulse);
                presenting = 1'b0;
            end
            // hold off for the drawn gap, then put the next tick on the bus
            if (!presenting && tick_q.size() != 0) begin
                if (tx_wait == 0) begin
                    nxt = tick_q.pop_front();
                    i_s_axis_tdata <= {{(IN_TDATA_W-1){1'b0}}, nxt.level};
                    tx_wait = (tick_q.size() != 0) ? tick_q[0].gap : 0;
                    presenting = 1'b1;
                end else begin
                    tx_wait--;
                end
            end
            i_s_axis_tvalid <= presenting;
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: take results with random back-pressure, compare with the
    // oldest prediction field by field
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_results
        t_result got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_result'(o_m_axis_tdata[RESULT_W-1:0]);
                if (verdict_q.size() == 0) begin
                    $error("result %b arrived with no tick outstanding", got);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("toggle_pulse", want.toggle_pulse, got.toggle_pulse);
                    check_field("enter_service_pulse", want.enter_service_pulse,
                                got.enter_service_pulse);
                    check_field("restart_pulse", want.restart_pulse, got.restart_pulse);
                    check_field("service_mode", want.service_mode, got.service_mode);
                    check_field("lockout", want.lockout, got.lockout);
                end
                rx_wait = draw_gap();
            end
            if (rx_wait != 0) begin
                rx_wait--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run once neither side has moved for too long.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("no transfer for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // Queue n ticks at one level, or at random levels when scramble is set.
    task automatic push_ticks(input logic level, input int unsigned n, input logic scramble);
        for (int unsigned k = 0; k < n; k++)
            tick_q.push_back('{scramble ? logic'($urandom_range(0, 1)) : level, draw_gap()});
    endtask

    // Queue a short directed pattern, leftmost bit first.
    task automatic push_pattern(input logic [31:0] levels, input int n);
        for (int k = n - 1; k >= 0; k--)
            push_ticks(levels[k], 1, 1'b0);
    endtask

    // Write one register at the next edge and track it in the shadow copy.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CFG_DEBOUNCE:     cfg_shadow.debounce_ticks         = value[TICKS_W-1:0];
            CFG_HOLD:         cfg_shadow.hold_ticks             = value[TICKS_W-1:0];
            CFG_SVC_TIMEOUT:  cfg_shadow.service_timeout_ticks  = value[TIMEOUT_W-1:0];
            CFG_REL_DEBOUNCE: cfg_shadow.release_debounce_ticks = value[TICKS_W-1:0];
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] debounce, hold, timeout, rel);
        write_reg(CFG_DEBOUNCE, debounce);
        write_reg(CFG_HOLD, hold);
        write_reg(CFG_SVC_TIMEOUT, timeout);
        write_reg(CFG_REL_DEBOUNCE, rel);
        end_writes();
    endtask

    // Wait until every queued tick is sent and every result is back, then
    // let the output stage idle before touching registers.
    task automatic settle();
        do @(negedge i_clk);
        while (tick_q.size() != 0 || i_s_axis_tvalid || verdict_q.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    // Largest value of a register, or of the small range the random phases use.
    function automatic int unsigned reg_span(input t_cfg_idx idx, input logic full);
        case (idx)
            CFG_DEBOUNCE:     return full ? 32'hFFFF   : 8;
            CFG_HOLD:         return full ? 32'hFFFF   : 12;
            CFG_SVC_TIMEOUT:  return full ? 32'hFFFFFF : 60;
            default:          return full ? 32'hFFFF   : 10;
        endcase
    endfunction

    // Run length close to a threshold, so both sides of it get hit; above 200 a short run.
    function automatic int unsigned near_len(input int unsigned x);
        int unsigned lo;
        if (x > 200)
            return $urandom_range(1, 40);
        lo = (x > 2) ? x - 2 : 1;
        return $urandom_range(x + 2, lo);
    endfunction

    // Alternate press and release runs sized around the live thresholds,
    // with a tenth of the runs replaced by random chatter.
    task automatic fill_random(input int unsigned n_items);
        int unsigned added, len, sel;
        logic        lvl;
        added = 0;
        lvl   = 1'b1;
        while (added < n_items) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1:    len = $urandom_range(1, 3);
                2, 3, 4: len = near_len(cfg_shadow.hold_ticks);
                5, 6:    len = near_len(cfg_shadow.debounce_ticks);
                7, 8:    len = near_len(cfg_shadow.release_debounce_ticks);
                default: len = near_len(cfg_shadow.service_timeout_ticks);
            endcase
            push_ticks(lvl, len, sel == 0);
            lvl = ~lvl;
            added += len;
        end
    endtask

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial begin
        logic [CFG_DATA_W-1:0] value;
        int unsigned           pick;
        t_cfg_idx              idx;

        cfg_shadow.debounce_ticks         = DEBOUNCE_RST;
        cfg_shadow.hold_ticks             = HOLD_RST;
        cfg_shadow.service_timeout_ticks  = SVC_TIMEOUT_RST;
        cfg_shadow.release_debounce_ticks = REL_DEBOUNCE_RST;
        clear_tracker();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: a short click gives a toggle and starts the lockout.
        push_pattern(32'b11000, 5);
        settle();

        // All registers zero: a press enters service on its first tick and the
        // next tick already exceeds the zero timeout.
        write_all('0, '0, '0, '0);
        push_pattern(32'b1010, 4);
        settle();

        // Timeout and re-press land on the same tick: one restart pulse.
        write_reg(CFG_SVC_TIMEOUT, 24'd3);
        end_writes();
        push_pattern(32'b100010, 6);
        settle();

        // Presses during the lockout, its last tick included, are ignored;
        // then a full hold, a release and a re-press after the gap.
        write_all(24'd2, 24'd3, 24'hFFFFFF, 24'd2);
        push_pattern(32'b10111111001, 11);
        settle();

        // Hold time, timeout and re-press gap at their maximum, junk in the
        // upper bits of the debounce write: a long press still ends as a
        // click, and only the low bits set the lockout length.
        pace = PACE_NONE;
        write_all(24'hFF0003, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        push_ticks(1'b1, 40, 1'b0);
        push_ticks(1'b0, 1, 1'b0);
        push_ticks(1'b0, 3, 1'b1);
        push_ticks(1'b1, 20, 1'b1);
        push_pattern(32'b0001, 4);
        settle();

        // Random phases, each with fresh settings; the first rewrites all
        // registers, later ones a random subset. Unused upper bits of the
        // 16-bit registers carry junk that must be dropped.
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            pace = t_pace'($urandom_range(0, 2));
            for (int r = 0; r < 4; r++) begin
                idx = t_cfg_idx'(r);
                if (ph == 0 || $urandom_range(0, 1) == 1) begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        value = '0;
                    else if (pick == 1)
                        value = CFG_DATA_W'(reg_span(idx, 1'b1));
                    else
                        value = CFG_DATA_W'($urandom_range(0, reg_span(idx, 1'b0)));
                    if (idx != CFG_SVC_TIMEOUT)
                        value[CFG_DATA_W-1:TICKS_W] = 8'($urandom_range(0, 255));
                    write_reg(idx, value);
                end
            end
            end_writes();
            fill_random(PHASE_TICKS);
            settle();
        end

        repeat (4) @(posedge i_clk);
        $display("%0d ticks checked over %0d register settings", n_ticks, PHASES + 5);
        $display("%0d clicks, %0d service entries, %0d restart requests, %0d errors",
                 n_clicks, n_entries, n_restarts, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
